@@ rtl/core/tts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and codes for the time-triggered task scheduler core.
// ----------------------------------------------------------------------------
package tts_pkg;

   // Task index field width on the request port (up to 16 slots)
   localparam int unsigned TASK_IDX_W   = 4;
   localparam int unsigned TIME_W       = 16;
   localparam int unsigned COUNT_W      = 8;
   localparam int unsigned NUM_TASKS_DF = 8;

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_TICK       = 2'd2,
      OP_DISPATCH   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BOUNDS      = 2'd1,
      ST_ZERO_PERIOD = 2'd2,
      ST_BUSY        = 2'd3
   } status_type;

   // One task table entry
   typedef struct packed {
      logic [TIME_W-1:0]  ticks;
      logic [TIME_W-1:0]  reload;
      logic [COUNT_W-1:0] act_cnt;
      logic [COUNT_W-1:0] inv_cnt;
   } entry_type;

   // Table access: one write and one read port per cycle
   typedef struct packed {
      logic                  we;
      logic [TASK_IDX_W-1:0] waddr;
      entry_type             wdata;
      logic                  re;
      logic [TASK_IDX_W-1:0] raddr;
   } mem_req_type;

   // Finished transaction result
   typedef struct packed {
      status_type            status;
      logic                  run_valid;
      logic [TASK_IDX_W-1:0] run_task;
      logic                  wake;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/core/tts_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_table
// Task table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tts_table
   import tts_pkg::*;
#(
   parameter int unsigned NUM_TASKS = NUM_TASKS_DF
) (
   input  wire logic        clock,
   input  wire mem_req_type mreq,
   output entry_type        rdata
);

   localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   entry_type mem [NUM_TASKS];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mreq.we) begin
         mem[mreq.waddr[IDX_W-1:0]] <= mreq.wdata;
      end
      if (mreq.re) begin
         rdata_ff <= mem[mreq.raddr[IDX_W-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/core/tts_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_seq
// Operation sequencer: slot-active flags, table sweeps for tick and dispatch.
// ----------------------------------------------------------------------------
module tts_seq
   import tts_pkg::*;
#(
   parameter int unsigned NUM_TASKS = NUM_TASKS_DF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [TASK_IDX_W-1:0] req_task_index,
   input  wire logic [TIME_W-1:0]     req_phasing,
   input  wire logic [TIME_W-1:0]     req_period,
   output mem_req_type                mreq,
   input  wire entry_type             rdata,
   output logic                       res_valid,
   output result_type                 res,
   input  wire logic                  res_take
);

   localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int unsigned CMP_W = TASK_IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_TASKS - 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_TICK = 4'b0010,
      S_DISP = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic [NUM_TASKS-1:0] active_ff, active_in;
   result_type           res_ff, res_in;

   logic                 in_range;
   logic [IDX_W-1:0]     req_idx;
   entry_type            upd;
   logic                 cur_active;

   assign in_range   = {1'b0, req_task_index} < CMP_W'(NUM_TASKS);
   assign req_idx    = req_task_index[IDX_W-1:0];
   assign cur_active = active_ff[cur_ff];

   // Tick update of the entry just read
   always_comb begin
      upd = rdata;
      if (rdata.ticks == '0) begin
         upd.ticks   = rdata.reload - TIME_W'(1);
         upd.act_cnt = rdata.act_cnt + COUNT_W'(1);
      end else begin
         upd.ticks   = rdata.ticks - TIME_W'(1);
      end
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      active_in = active_ff;
      res_in    = res_ff;
      mreq      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               unique case (op_type'(req_opcode))
                  OP_REGISTER: begin
                     priority if (!in_range) begin
                        res_in.status = ST_BOUNDS;
                     end else if (req_period == '0) begin
                        res_in.status = ST_ZERO_PERIOD;
                     end else if (active_ff[req_idx]) begin
                        res_in.status = ST_BUSY;
                     end else begin
                        active_in[req_idx]   = 1'b1;
                        mreq.we              = 1'b1;
                        mreq.waddr           = req_task_index;
                        mreq.wdata.ticks     = req_phasing;
                        mreq.wdata.reload    = req_period;
                        mreq.wdata.act_cnt   = '0;
                        mreq.wdata.inv_cnt   = '0;
                     end
                     state_in = S_DONE;
                  end
                  OP_UNREGISTER: begin
                     if (!in_range) begin
                        res_in.status = ST_BOUNDS;
                     end else begin
                        active_in[req_idx] = 1'b0;
                     end
                     state_in = S_DONE;
                  end
                  OP_TICK: begin
                     mreq.re    = 1'b1;
                     mreq.raddr = '0;
                     cur_in     = '0;
                     state_in   = S_TICK;
                  end
                  OP_DISPATCH: begin
                     mreq.re    = 1'b1;
                     mreq.raddr = TASK_IDX_W'(LAST);
                     cur_in     = LAST;
                     state_in   = S_DISP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_TICK: begin
            // write back entry cur, read cur+1: never the same slot
            if (cur_active) begin
               mreq.we    = 1'b1;
               mreq.waddr = TASK_IDX_W'(cur_ff);
               mreq.wdata = upd;
               if (upd.act_cnt != upd.inv_cnt) begin
                  res_in.wake = 1'b1;
               end
            end
            if (cur_ff == LAST) begin
               state_in = S_DONE;
            end else begin
               mreq.re    = 1'b1;
               mreq.raddr = TASK_IDX_W'(cur_ff) + TASK_IDX_W'(1);
               cur_in     = cur_ff + IDX_W'(1);
            end
         end
         S_DISP: begin
            // inactive slots are skipped; their counts are cleared on register
            if (cur_active && (rdata.act_cnt != rdata.inv_cnt)) begin
               mreq.we               = 1'b1;
               mreq.waddr            = TASK_IDX_W'(cur_ff);
               mreq.wdata            = rdata;
               mreq.wdata.inv_cnt    = rdata.inv_cnt + COUNT_W'(1);
               res_in.run_valid      = 1'b1;
               res_in.run_task       = TASK_IDX_W'(cur_ff);
               state_in              = S_DONE;
            end else if (cur_ff == '0) begin
               state_in = S_DONE;
            end else begin
               mreq.re    = 1'b1;
               mreq.raddr = TASK_IDX_W'(cur_ff) - TASK_IDX_W'(1);
               cur_in     = cur_ff - IDX_W'(1);
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

endmodule
`default_nettype wire

@@ rtl/core/time_triggered_task_scheduler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler_core
// Fixed-priority, non-preemptive periodic task scheduler with a memory table.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction, in order.
// Slot i is priority level i (higher index wins). Register and unregister
// are decided in the idle state and wait in the done state until the
// response register takes the result. A timer tick reads, updates and
// writes back every slot in turn through the single-read-port task table.
// Dispatch scans from the highest slot downward, one table read per cycle,
// and stops at the first pending active slot. The table read port (one
// entry per cycle) bounds tick and dispatch. A new request is taken only
// when the sequencer is idle; the response register lets a finished result
// wait for rsp_ready while the next request is already being processed.
// Slot-active flags live in flops and clear on reset; the table itself needs
// no clearing pass since an entry is always written on register before use.
// ----------------------------------------------------------------------------
module time_triggered_task_scheduler_core
   import tts_pkg::*;
#(
   parameter int unsigned NUM_TASKS = NUM_TASKS_DF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [TASK_IDX_W-1:0] req_task_index,
   input  wire logic [TIME_W-1:0]     req_phasing,
   input  wire logic [TIME_W-1:0]     req_period,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_run_valid,
   output logic [TASK_IDX_W-1:0]      rsp_run_task,
   output logic                       rsp_wake
);

   mem_req_type mreq;
   entry_type   rdata;
   logic        res_valid;
   result_type  res;
   logic        out_free;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   tts_table #(
      .NUM_TASKS (NUM_TASKS)
   ) u_table (
      .clock (clock),
      .mreq  (mreq),
      .rdata (rdata)
   );

   tts_seq #(
      .NUM_TASKS (NUM_TASKS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_task_index (req_task_index),
      .req_phasing    (req_phasing),
      .req_period     (req_period),
      .mreq           (mreq),
      .rdata          (rdata),
      .res_valid      (res_valid),
      .res            (res),
      .res_take       (out_free)
   );

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_ff.status;
   assign rsp_run_valid = rsp_ff.run_valid;
   assign rsp_run_task  = rsp_ff.run_task;
   assign rsp_wake      = rsp_ff.wake;

endmodule
`default_nettype wire

@@ rtl/core/tts_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tts_checker
// Port-level assertions for the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker
   import tts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [TASK_IDX_W-1:0] req_task_index,
   input  wire logic [TIME_W-1:0]     req_phasing,
   input  wire logic [TIME_W-1:0]     req_period,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [1:0]            rsp_status,
   input  wire logic                  rsp_run_valid,
   input  wire logic [TASK_IDX_W-1:0] rsp_run_task,
   input  wire logic                  rsp_wake
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_run_valid) && $stable(rsp_run_task) && $stable(rsp_wake))
      else $error("response changed while stalled");

   // a dispatch hit carries no status and no wake
   a_run_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_valid |-> rsp_status == ST_OK && !rsp_wake)
      else $error("dispatch result mixed with other fields");

   // no dispatch hit means task field is zero
   a_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_valid |-> rsp_run_task == '0)
      else $error("run_task set without run_valid");

   // an accepted request never yields a response in the cycle after it is taken
   a_no_zero_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared one cycle after request");

   // nothing is reported right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind time_triggered_task_scheduler_core tts_checker u_tts_checker (.*);
`default_nettype wire

@@ sim/tts_schedule_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tts_schedule_checker
// Observes the request and response channels of the scheduler core. It keeps
// a private copy of the task table, works out the response of every accepted
// request and compares each accepted response against it field by field.
// ----------------------------------------------------------------------------
module tts_schedule_checker
   import tts_pkg::*;
#(
   parameter int unsigned NUM_TASKS = NUM_TASKS_DF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_opcode,
   input  logic [TASK_IDX_W-1:0] req_task_index,
   input  logic [TIME_W-1:0]     req_phasing,
   input  logic [TIME_W-1:0]     req_period,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [1:0]            rsp_status,
   input  logic                  rsp_run_valid,
   input  logic [TASK_IDX_W-1:0] rsp_run_task,
   input  logic                  rsp_wake,
   output int unsigned           mismatches,
   output int unsigned           outstanding,
   output int unsigned           tasks_run,
   output int unsigned           wakeups
);

   localparam int unsigned REPORT_LIMIT = 20;

   logic [NUM_TASKS-1:0] slot_live;
   logic [TIME_W-1:0]    countdown   [NUM_TASKS];
   logic [TIME_W-1:0]    reload_val  [NUM_TASKS];
   logic [COUNT_W-1:0]   releases    [NUM_TASKS];
   logic [COUNT_W-1:0]   invocations [NUM_TASKS];
   result_type           expected_q  [$];

   // Applies one request to the shadow table and returns its response.
   function automatic result_type advance_schedule(op_type op,
                                                   logic [TASK_IDX_W-1:0] slot,
                                                   logic [TIME_W-1:0] phase,
                                                   logic [TIME_W-1:0] span);
      result_type outcome;
      logic       found;
      outcome = '0;
      found   = 1'b0;
      case (op)
         OP_REGISTER: begin
            // bound first, then period, then occupancy
            if (slot >= NUM_TASKS) outcome.status = ST_BOUNDS;
            else if (span == '0) outcome.status = ST_ZERO_PERIOD;
            else if (slot_live[slot]) outcome.status = ST_BUSY;
            else begin
               slot_live[slot]   = 1'b1;
               countdown[slot]   = phase;
               reload_val[slot]  = span;
               releases[slot]    = '0;
               invocations[slot] = '0;
            end
         end
         OP_UNREGISTER: begin
            if (slot >= NUM_TASKS) outcome.status = ST_BOUNDS;
            else slot_live[slot] = 1'b0;
         end
         OP_TICK: begin
            for (int i = 0; i < NUM_TASKS; i++) begin
               if (slot_live[i]) begin
                  if (countdown[i] == '0) begin
                     countdown[i] = reload_val[i] - 1'b1;
                     releases[i]  = releases[i] + 1'b1;
                  end else begin
                     countdown[i] = countdown[i] - 1'b1;
                  end
               end
            end
            for (int i = 0; i < NUM_TASKS; i++)
               if (slot_live[i] && releases[i] != invocations[i]) outcome.wake = 1'b1;
         end
         OP_DISPATCH: begin
            for (int i = NUM_TASKS - 1; i >= 0; i--) begin
               if (!found && releases[i] != invocations[i]) begin
                  if (slot_live[i]) begin
                     invocations[i]    = invocations[i] + 1'b1;
                     outcome.run_valid = 1'b1;
                     outcome.run_task  = TASK_IDX_W'(i);
                     found             = 1'b1;
                  end else begin
                     // freed slot with stale activations: drop them, keep scanning
                     invocations[i] = releases[i];
                  end
               end
            end
         end
      endcase
      return outcome;
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: rsp_%s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type seen;
      result_type due;
      if (reset) begin
         slot_live = '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            countdown[i]   = '0;
            reload_val[i]  = '0;
            releases[i]    = '0;
            invocations[i] = '0;
         end
         expected_q.delete();
         mismatches = 0;
         tasks_run  = 0;
         wakeups    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.status    = status_type'(rsp_status);
            seen.run_valid = rsp_run_valid;
            seen.run_task  = rsp_run_task;
            seen.wake      = rsp_wake;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: response with none expected, actual %b", $time, seen);
            end else begin
               due = expected_q.pop_front();
               check_field("status", due.status, seen.status);
               check_field("run_valid", due.run_valid, seen.run_valid);
               check_field("run_task", due.run_task, seen.run_task);
               check_field("wake", due.wake, seen.wake);
            end
         end
         if (req_valid && req_ready) begin
            due = advance_schedule(op_type'(req_opcode), req_task_index,
                                   req_phasing, req_period);
            if (due.run_valid) tasks_run++;
            if (due.wake) wakeups++;
            expected_q.push_back(due);
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

@@ sim/tb_time_triggered_task_scheduler_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_triggered_task_scheduler_core
// Drives register, unregister, tick and dispatch transactions into the
// scheduler core with random idle gaps on both channels; a checker module
// beside the core predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_time_triggered_task_scheduler_core;
   import tts_pkg::*;

   localparam int unsigned RANDOM_ITEMS  = 1950;
   // longest core operation is a full table walk
   localparam int unsigned SETTLE_CYCLES = 2 * (NUM_TASKS_DF + 2);

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_opcode     = '0;
   logic [TASK_IDX_W-1:0] req_task_index = '0;
   logic [TIME_W-1:0]     req_phasing    = '0;
   logic [TIME_W-1:0]     req_period     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [1:0]            rsp_status;
   logic                  rsp_run_valid;
   logic [TASK_IDX_W-1:0] rsp_run_task;
   logic                  rsp_wake;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned tasks_run;
   int unsigned wakeups;

   bit          steady = 1'b0;   // set: neither side idles
   int unsigned sent;
   int unsigned op_tally [4];
   int unsigned wrap_runs;

   time_triggered_task_scheduler_core i_dut (.*);

   tts_schedule_checker i_schedule_checker (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop in case the core hangs on a handshake
   initial begin
      #4_000_000;
      $display("tb_time_triggered_task_scheduler_core: errors");
      $finish;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int unsigned idle_span();
      int unsigned roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Small phases and periods keep activations frequent; a few are full range
   // and a few are zero (a rejected period).
   function automatic logic [TIME_W-1:0] pick_time(int unsigned lo);
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return TIME_W'($urandom);
      if (roll == 1) return '0;
      return TIME_W'($urandom_range(lo, 6));
   endfunction

   // Mostly valid slots, sometimes out of range.
   function automatic logic [TASK_IDX_W-1:0] pick_slot();
      if ($urandom_range(0, 9) == 0) return TASK_IDX_W'($urandom_range(0, 15));
      return TASK_IDX_W'($urandom_range(0, NUM_TASKS_DF - 1));
   endfunction

   // One request transaction. valid is only lowered when an idle gap is
   // inserted, so back-to-back transactions keep it high through the edge.
   task automatic issue(op_type op, logic [TASK_IDX_W-1:0] slot,
                        logic [TIME_W-1:0] phase, logic [TIME_W-1:0] span);
      int unsigned gap;
      gap = idle_span();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_task_index <= slot;
      req_phasing    <= phase;
      req_period     <= span;
      do @(posedge clock); while (!req_ready);
      sent++;
      op_tally[op]++;
   endtask

   // tick and dispatch carry random junk in the fields they ignore
   task automatic tick();
      issue(OP_TICK, TASK_IDX_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
   endtask

   task automatic dispatch();
      issue(OP_DISPATCH, TASK_IDX_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
   endtask

   // Well-formed scenario: fill a few slots, then interleave ticks and
   // dispatches, with the odd unregister or late register in between.
   task automatic run_workload();
      int unsigned roll;
      repeat ($urandom_range(1, 4)) issue(OP_REGISTER, pick_slot(), pick_time(0), pick_time(1));
      repeat ($urandom_range(10, 40)) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) tick();
         else if (roll < 93) dispatch();
         else if (roll < 97)
            issue(OP_UNREGISTER, pick_slot(), TIME_W'($urandom), TIME_W'($urandom));
         else issue(OP_REGISTER, pick_slot(), pick_time(0), pick_time(1));
      end
      // half the time free the whole table so later registers succeed
      if ($urandom_range(0, 1) == 1)
         for (int s = 0; s < NUM_TASKS_DF; s++)
            issue(OP_UNREGISTER, TASK_IDX_W'(s), TIME_W'($urandom), TIME_W'($urandom));
   endtask

   // Unstructured transactions: any opcode, any field value.
   task automatic run_noise();
      repeat ($urandom_range(5, 20))
         issue(op_type'($urandom_range(0, 3)), TASK_IDX_W'($urandom),
               TIME_W'($urandom), TIME_W'($urandom));
   endtask

   // A period-1 task ticked 250 to 280 times with nothing dispatched: the
   // activation count often wraps, sometimes landing back on the invocation count.
   task automatic run_counter_wrap();
      logic [TASK_IDX_W-1:0] slot;
      slot = TASK_IDX_W'($urandom_range(0, NUM_TASKS_DF - 1));
      issue(OP_UNREGISTER, slot, TIME_W'($urandom), TIME_W'($urandom));
      issue(OP_REGISTER, slot, '0, 16'd1);
      repeat ($urandom_range(250, 280)) tick();
      repeat ($urandom_range(4, 30)) dispatch();
      wrap_runs++;
   endtask

   // Response side: ready drops for random stretches, except in steady phases.
   initial begin : rsp_side
      int unsigned stall;
      @(posedge clock);
      forever begin
         stall = idle_span();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned base;
      int unsigned roll;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed: status codes, priority order, stale activations ---
      issue(OP_DISPATCH, 4'hF, 16'hFFFF, 16'hFFFF);        // empty table, nothing to run
      issue(OP_TICK, 4'h0, 16'h0000, 16'h0000);            // tick with no task, no wake
      issue(OP_REGISTER, 4'd0, 16'h0000, 16'h0001);        // lowest slot, fires every tick
      issue(OP_REGISTER, 4'd15, 16'hFFFF, 16'hFFFF);       // index beyond the table
      issue(OP_REGISTER, TASK_IDX_W'(NUM_TASKS_DF), 16'h0001, 16'h0000); // bound before period
      issue(OP_REGISTER, 4'd3, 16'h1234, 16'h0000);        // zero period
      issue(OP_REGISTER, 4'd0, 16'h0000, 16'h0000);        // period checked before busy
      issue(OP_REGISTER, 4'd0, 16'h0005, 16'h0003);        // slot busy
      issue(OP_REGISTER, 4'd7, 16'hFFFF, 16'hFFFF);        // top slot, longest countdown
      issue(OP_REGISTER, 4'd5, 16'h0001, 16'h0002);
      tick();
      tick();
      repeat (4) dispatch();                               // 5 first, then 0 twice, then idle
      issue(OP_UNREGISTER, 4'd15, 16'hFFFF, 16'hFFFF);     // unregister out of range
      issue(OP_UNREGISTER, 4'd4, 16'h0000, 16'h0000);      // unregister of a free slot
      tick();
      tick();
      issue(OP_UNREGISTER, 4'd5, 16'h0000, 16'h0000);      // leaves slot 5 pending, inactive
      dispatch();                                          // slot 5 dropped, slot 0 runs
      issue(OP_UNREGISTER, 4'd0, 16'h0000, 16'h0000);
      tick();                                              // pending but inactive: no wake
      dispatch();                                          // stale slot 0 dropped, nothing runs
      issue(OP_UNREGISTER, 4'd7, 16'h0000, 16'h0000);

      // --- random scenarios ---
      base = sent;
      while (sent - base < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         roll   = $urandom_range(0, 99);
         if (wrap_runs == 0 || roll < 2) run_counter_wrap();
         else if (roll < 80) run_workload();
         else run_noise();
      end

      // drain: the checker's count is registered, so it lags the last transaction
      req_valid <= 1'b0;
      steady = 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("coverage: %0d transactions (%0d register, %0d unregister, %0d tick, %0d dispatch)",
               sent, op_tally[OP_REGISTER], op_tally[OP_UNREGISTER], op_tally[OP_TICK],
               op_tally[OP_DISPATCH]);
      $display("coverage: %0d dispatches ran a task, %0d ticks raised wake, %0d wrap scenarios",
               tasks_run, wakeups, wrap_runs);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_time_triggered_task_scheduler_core: clean");
      end else begin
         $display("tb_time_triggered_task_scheduler_core: errors");
      end
      $finish;
   end

endmodule
